// ----- sv/fhc_pkg.sv -----
// Shared types, constants and functions for the flash hypothesis compatibility block.
package fhc_pkg;

	localparam int PE_W       = 20;
	localparam int SUM_W      = 28;
	localparam int CUT_W      = 13;
	localparam int MAG_W      = 13;
	localparam int SQ_W       = 25;
	localparam int CFG_IDX_W  = 2;
	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_W    = 2;
	localparam int CH_PROD_W  = 45;
	localparam int IN_LHS_W   = 60;
	localparam int IN_RHS_W   = 53;

	localparam logic [CUT_W-1:0] CUT_RESET = 13'd48;

	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_CUT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_CUT = 2'd1;

	typedef enum logic [1:0] {
		FR_NONE     = 2'd0,
		FR_CHANNEL  = 2'd1,
		FR_INTEGRAL = 2'd2
	} fail_reason_t;

	typedef struct packed {
		logic [PE_W-1:0] hyp_pe;
		logic [PE_W-1:0] sig_pe;
		logic            last_channel;
	} fhc_in_t;

	typedef struct packed {
		logic         compatible;
		fail_reason_t fail_reason;
	} fhc_out_t;

	// one finished flash handed from front to back
	typedef struct packed {
		logic             channel_failed;
		logic [SUM_W-1:0] hyp_sum;
		logic [SUM_W-1:0] sig_sum;
	} fhc_flash_t;

	// cut in test form: sign and squared magnitude
	typedef struct packed {
		logic            neg;
		logic [SQ_W-1:0] sq;
	} cut_t;

	function automatic cut_t cut_prep(input logic [CUT_W-1:0] raw);
		logic [MAG_W-1:0] mag;
		cut_t             c;
		mag   = raw[CUT_W-1] ? MAG_W'(-raw) : raw;
		c.neg = raw[CUT_W-1];
		c.sq  = SQ_W'(mag) * SQ_W'(mag);
		return c;
	endfunction

	// gt: 16*d*d > c*c*h, lt: 16*d*d < c*c*h
	function automatic logic exceeds(input logic dpos, input logic cneg,
			input logic gt, input logic lt);
		return dpos ? (cneg | gt) : (cneg & lt);
	endfunction

endpackage

// ----- sv/fhc_front.sv -----
// Front end: accepts channel pairs, runs the per-channel test and accumulates the flash sums.
module fhc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  fhc_pkg::fhc_in_t   in_data,
	input  fhc_pkg::cut_t      cut,
	input  logic               q_full,
	output logic               q_push,
	output fhc_pkg::fhc_flash_t q_data
);
	import fhc_pkg::*;

	logic                 adv;
	logic                 accept;
	logic [SUM_W:0]       h_add;
	logic [SUM_W:0]       s_add;
	logic [SUM_W-1:0]     h_sat;
	logic [SUM_W-1:0]     s_sat;
	logic [SUM_W-1:0]     hsum_q;
	logic [SUM_W-1:0]     ssum_q;
	logic                 failed_q;

	logic                 v_s1;
	logic                 last_s1;
	logic                 dpos_s1;
	logic [PE_W-1:0]      dm_s1;
	logic [PE_W-1:0]      h_s1;
	logic [SUM_W-1:0]     hsum_s1;
	logic [SUM_W-1:0]     ssum_s1;

	logic [2*PE_W-1:0]    dsq;
	logic [CH_PROD_W-1:0] rhs_c;

	logic                 v_s2;
	logic                 last_s2;
	logic                 dpos_s2;
	logic [CH_PROD_W-1:0] lhs_s2;
	logic [CH_PROD_W-1:0] rhs_s2;
	logic [SUM_W-1:0]     hsum_s2;
	logic [SUM_W-1:0]     ssum_s2;
	logic                 exc;

	assign adv      = !(v_s2 && last_s2 && q_full);
	assign in_stall = !adv;
	assign accept   = in_valid && adv;

	assign h_add = {1'b0, hsum_q} + (SUM_W+1)'(in_data.hyp_pe);
	assign s_add = {1'b0, ssum_q} + (SUM_W+1)'(in_data.sig_pe);
	assign h_sat = h_add[SUM_W] ? '1 : h_add[SUM_W-1:0];
	assign s_sat = s_add[SUM_W] ? '1 : s_add[SUM_W-1:0];

	assign dsq   = dm_s1 * dm_s1;
	assign rhs_c = cut.sq * h_s1;

	assign exc = exceeds(dpos_s2, cut.neg, lhs_s2 > rhs_s2, lhs_s2 < rhs_s2);

	assign q_push = adv && v_s2 && last_s2;
	assign q_data = '{channel_failed: failed_q | exc, hyp_sum: hsum_s2, sig_sum: ssum_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			hsum_q   <= '0;
			ssum_q   <= '0;
			failed_q <= 1'b0;
		end else begin
			if (adv) begin
				v_s1 <= accept;
				v_s2 <= v_s1;
			end
			if (accept) begin
				hsum_q <= in_data.last_channel ? '0 : h_sat;
				ssum_q <= in_data.last_channel ? '0 : s_sat;
			end
			if (adv && v_s2) begin
				failed_q <= last_s2 ? 1'b0 : (failed_q | exc);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= in_data.last_channel;
			dpos_s1 <= in_data.hyp_pe > in_data.sig_pe;
			dm_s1   <= (in_data.hyp_pe > in_data.sig_pe) ? in_data.hyp_pe - in_data.sig_pe
				: in_data.sig_pe - in_data.hyp_pe;
			h_s1    <= in_data.hyp_pe;
			hsum_s1 <= h_sat;
			ssum_s1 <= s_sat;
			last_s2 <= last_s1;
			dpos_s2 <= dpos_s1;
			lhs_s2  <= {1'b0, dsq, 4'b0000};
			rhs_s2  <= rhs_c;
			hsum_s2 <= hsum_s1;
			ssum_s2 <= ssum_s1;
		end
	end

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("flash pushed into a full queue");

	a_flag_clears: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |=> !failed_q)
		else $error("channel fail flag survived end of flash");

endmodule

// ----- sv/fhc_queue.sv -----
// Short FIFO of finished flashes between front and back.
module fhc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  fhc_pkg::fhc_flash_t push_data,
	output logic                full,
	input  logic                pop,
	output logic                empty,
	output fhc_pkg::fhc_flash_t pop_data
);
	import fhc_pkg::*;

	fhc_flash_t          entries_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wr_ptr_q;
	logic [Q_PTR_W-1:0]  rd_ptr_q;
	logic [Q_PTR_W:0]    cnt_q;

	assign full     = cnt_q == (Q_PTR_W+1)'(Q_DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (Q_PTR_W+1)'(Q_DEPTH))
		else $error("queue count out of range");

endmodule

// ----- sv/fhc_back.sv -----
// Back end: integral test on the flash sums and verdict output register.
module fhc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	output logic                q_pop,
	input  fhc_pkg::fhc_flash_t q_data,
	input  fhc_pkg::cut_t       cut,
	output logic                out_valid,
	input  logic                out_stall,
	output fhc_pkg::fhc_out_t   out_data
);
	import fhc_pkg::*;

	logic                adv;
	logic                v_b1;
	logic                fail_b1;
	logic                dpos_b1;
	logic [SUM_W-1:0]    dm_b1;
	logic [SUM_W-1:0]    h_b1;
	logic [2*SUM_W-1:0]  dsq;
	logic [IN_RHS_W-1:0] rhs_c;
	logic                v_b2;
	logic                fail_b2;
	logic                dpos_b2;
	logic [IN_LHS_W-1:0] lhs_b2;
	logic [IN_LHS_W-1:0] rhs_b2;
	logic                exc;
	logic                out_valid_q;
	fhc_out_t            out_q;
	fhc_out_t            verdict;

	assign adv   = !out_valid_q || !out_stall;
	assign q_pop = adv && !q_empty;

	assign dsq   = dm_b1 * dm_b1;
	assign rhs_c = cut.sq * h_b1;
	assign exc   = exceeds(dpos_b2, cut.neg, lhs_b2 > rhs_b2, lhs_b2 < rhs_b2);

	always_comb begin
		if (fail_b2) begin
			verdict = '{compatible: 1'b0, fail_reason: FR_CHANNEL};
		end else if (exc) begin
			verdict = '{compatible: 1'b0, fail_reason: FR_INTEGRAL};
		end else begin
			verdict = '{compatible: 1'b1, fail_reason: FR_NONE};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1        <= 1'b0;
			v_b2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_b1        <= q_pop;
			v_b2        <= v_b1;
			out_valid_q <= v_b2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fail_b1 <= q_data.channel_failed;
			dpos_b1 <= q_data.hyp_sum > q_data.sig_sum;
			dm_b1   <= (q_data.hyp_sum > q_data.sig_sum) ? q_data.hyp_sum - q_data.sig_sum
				: q_data.sig_sum - q_data.hyp_sum;
			h_b1    <= q_data.hyp_sum;
			fail_b2 <= fail_b1;
			dpos_b2 <= dpos_b1;
			lhs_b2  <= {dsq, 4'b0000};
			rhs_b2  <= IN_LHS_W'(rhs_c);
			out_q   <= verdict;
		end
	end

	a_verdict_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.compatible) |-> (out_q.fail_reason == FR_NONE))
		else $error("compatible verdict carries a fail reason");

endmodule

// ----- sv/flash_hypothesis_compatibility.sv -----
// Top level of the flash hypothesis compatibility checker.
// Takes one channel pair (predicted, observed light) per clock, one transaction per cycle
// sustained while in_stall is low. After the transaction marked last is accepted, its
// flash verdict passes the second front stage, flash queue, two integral-test stages and
// output register, given an empty queue and no output stall. A four-deep queue of finished
// flashes decouples the front and back ends; output stalls hold input only once it fills.
// Write cut registers only while no flash is in flight; the block does not enforce this.
module flash_hypothesis_compatibility (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  fhc_pkg::fhc_in_t                  in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output fhc_pkg::fhc_out_t                 out_data,
	input  logic                              cfg_we,
	input  logic [fhc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fhc_pkg::CUT_W-1:0]         cfg_data
);
	import fhc_pkg::*;

	cut_t       chan_cut_q;
	cut_t       int_cut_q;
	logic       q_full;
	logic       q_empty;
	logic       q_push;
	logic       q_pop;
	fhc_flash_t q_wdata;
	fhc_flash_t q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_cut_q <= cut_prep(CUT_RESET);
			int_cut_q  <= cut_prep(CUT_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CHANNEL_CUT:  chan_cut_q <= cut_prep(cfg_data);
				CFG_INTEGRAL_CUT: int_cut_q  <= cut_prep(cfg_data);
				default: ;
			endcase
		end
	end

	fhc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.cut      (chan_cut_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	fhc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.pop_data  (q_rdata)
	);

	fhc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.q_data    (q_rdata),
		.cut       (int_cut_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ----- tb/fhc_verdict_pkg.sv -----
// Flash verdict predictor and scoreboard for the flash hypothesis compatibility testbench.
`timescale 1ns / 100ps

package fhc_verdict_pkg;

	import fhc_pkg::*;

	class flash_verdict_board;

		logic [CUT_W-1:0] channel_cut;
		logic [CUT_W-1:0] integral_cut;
		logic [SUM_W-1:0] hyp_sum;
		logic [SUM_W-1:0] sig_sum;
		bit               channel_failed;
		fhc_out_t         pending_verdicts[$];

		int unsigned channels_seen;
		int unsigned flashes_seen;
		int unsigned mismatches;
		int unsigned n_compatible;
		int unsigned n_channel_excess;
		int unsigned n_integral_excess;

		function new();
			channel_cut    = CUT_RESET;
			integral_cut   = CUT_RESET;
			hyp_sum        = '0;
			sig_sum        = '0;
			channel_failed = 1'b0;
		endfunction

		function void write_cut(logic [CFG_IDX_W-1:0] idx, logic [CUT_W-1:0] value);
			if (idx == CFG_CHANNEL_CUT) begin
				channel_cut = value;
			end else if (idx == CFG_INTEGRAL_CUT) begin
				integral_cut = value;
			end
		endfunction

		// 4*(h-s) > cut*sqrt(h), evaluated on squares
		function bit beyond_cut(logic [SUM_W-1:0] h, logic [SUM_W-1:0] s,
				logic [CUT_W-1:0] cut);
			logic [63:0] dmag;
			logic [63:0] cmag;
			logic [63:0] lhs;
			logic [63:0] rhs;
			bit          excess;
			bit          cneg;
			if (h == '0)
				return 1'b0;
			excess = h > s;
			dmag   = excess ? 64'(h) - 64'(s) : 64'(s) - 64'(h);
			cneg   = cut[CUT_W-1];
			cmag   = cneg ? (64'd1 << CUT_W) - 64'(cut) : 64'(cut);
			lhs    = 64'd16 * dmag * dmag;
			rhs    = cmag * cmag * 64'(h);
			if (excess)
				return cneg || (lhs > rhs);
			return cneg && (lhs < rhs);
		endfunction

		function logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] acc, logic [PE_W-1:0] v);
			logic [SUM_W:0] t;
			t = {1'b0, acc} + (SUM_W+1)'(v);
			return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
		endfunction

		function void note_channel(fhc_in_t ch);
			fhc_out_t verdict;
			channels_seen++;
			if (!channel_failed && beyond_cut(SUM_W'(ch.hyp_pe), SUM_W'(ch.sig_pe), channel_cut))
				channel_failed = 1'b1;
			hyp_sum = sat_add(hyp_sum, ch.hyp_pe);
			sig_sum = sat_add(sig_sum, ch.sig_pe);
			if (ch.last_channel) begin
				if (channel_failed) begin
					verdict.compatible  = 1'b0;
					verdict.fail_reason = FR_CHANNEL;
				end else if (beyond_cut(hyp_sum, sig_sum, integral_cut)) begin
					verdict.compatible  = 1'b0;
					verdict.fail_reason = FR_INTEGRAL;
				end else begin
					verdict.compatible  = 1'b1;
					verdict.fail_reason = FR_NONE;
				end
				pending_verdicts = {pending_verdicts, verdict};
				flashes_seen++;
				hyp_sum        = '0;
				sig_sum        = '0;
				channel_failed = 1'b0;
			end
		endfunction

		function void check_verdict(fhc_out_t got);
			fhc_out_t want;
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected verdict compatible=%0b fail_reason=%0d",
					$time, got.compatible, got.fail_reason);
				mismatches++;
				return;
			end
			want = pending_verdicts.pop_front();
			if (got.compatible !== want.compatible) begin
				$display("%0t: compatible mismatch: expected %0b, actual %0b",
					$time, want.compatible, got.compatible);
				mismatches++;
			end
			if (got.fail_reason !== want.fail_reason) begin
				$display("%0t: fail_reason mismatch: expected %0d, actual %0d",
					$time, want.fail_reason, got.fail_reason);
				mismatches++;
			end
			case (want.fail_reason)
				FR_CHANNEL:  n_channel_excess++;
				FR_INTEGRAL: n_integral_excess++;
				default:     n_compatible++;
			endcase
		endfunction

	endclass

endpackage

// ----- tb/testbench.sv -----
// Testbench top for the flash hypothesis compatibility block.
`timescale 1ns / 100ps

module testbench;

	import fhc_pkg::*;
	import fhc_verdict_pkg::*;

	localparam int PE_MAX       = (1 << PE_W) - 1;
	localparam int RANDOM_ITEMS = 1600;
	localparam int N_SETTINGS   = 9;
	localparam int SETTLE       = 12;
	localparam int DRAIN        = 20;
	localparam int IDLE_LIMIT   = 5000;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	typedef enum logic [1:0] {RX_FLOW, RX_RANDOM, RX_HOLD, RX_TOGGLE} rx_mode_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_stall;
	fhc_in_t  in_data = '0;
	logic     out_valid;
	logic     out_stall = 1'b0;
	fhc_out_t out_data;
	logic     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CUT_W-1:0]     cfg_data = '0;

	flash_verdict_board verdict_board;
	rx_mode_t rx_mode = RX_FLOW;
	int       rx_left = 0;
	int       burst_left = 0;
	int       idle_cycles = 0;
	int       random_items = 0;

	flash_hypothesis_compatibility u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// receiver back-pressure pattern
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(5, 60);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_FLOW:   out_stall <= 1'b0;
			RX_RANDOM: out_stall <= $urandom_range(0, 1);
			RX_HOLD:   out_stall <= 1'b1;
			default:   out_stall <= ~out_stall;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			verdict_board.check_verdict(out_data);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles = idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				gap        = 0;
				burst_left = $urandom_range(40, 150);
			end else begin
				gap        = $urandom_range(1, 6);
				burst_left = $urandom_range(1, 12);
			end
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic send_channel(input fhc_in_t ch);
		pace_sender();
		in_valid = 1'b1;
		in_data  = ch;
		do @(posedge clk); while (in_stall);
		verdict_board.note_channel(ch);
		@(negedge clk);
	endtask

	task automatic send_pair(input int h, input int s, input bit last);
		fhc_in_t ch;
		ch.hyp_pe       = h[PE_W-1:0];
		ch.sig_pe       = s[PE_W-1:0];
		ch.last_channel = last;
		send_channel(ch);
	endtask

	task automatic drain_verdicts(input int settle);
		in_valid = 1'b0;
		while (verdict_board.pending_verdicts.size() != 0) @(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_cut(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value[CUT_W-1:0];
		verdict_board.write_cut(idx, value[CUT_W-1:0]);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// channel values, biased toward the cut boundary
	function automatic fhc_in_t make_channel(input bit last, input bit near_full);
		fhc_in_t ch;
		int      cut;
		int      h;
		int      s;
		int      d0;
		int      pick;
		int      bits;
		cut  = int'($signed(verdict_board.channel_cut));
		pick = $urandom_range(0, 9);
		if (near_full) begin
			h  = PE_MAX - $urandom_range(0, 15);
			d0 = int'(cut * $sqrt(real'(h)) / 4.0);
			s  = ($urandom_range(0, 2) == 0) ? h
				: h - (d0 * int'($urandom_range(0, 90))) / 100;
		end else if (pick < 2) begin
			h = $urandom_range(0, PE_MAX);
			s = $urandom_range(0, PE_MAX);
		end else if (pick == 2) begin
			h = $urandom_range(0, 63);
			s = $urandom_range(0, 63);
		end else if (pick == 3) begin
			h = 0;
			s = $urandom_range(0, PE_MAX);
		end else if (pick == 4) begin
			h = $urandom_range(0, 1) ? PE_MAX : 0;
			s = $urandom_range(0, 1) ? PE_MAX : 0;
		end else begin
			bits = $urandom_range(1, PE_W);
			h    = $urandom_range(1, (1 << bits) - 1);
			d0   = int'(cut * $sqrt(real'(h)) / 4.0);
			s    = h - d0 + $urandom_range(0, 4) - 2;
		end
		if (s < 0)
			s = 0;
		if (s > PE_MAX)
			s = PE_MAX;
		ch.hyp_pe       = h[PE_W-1:0];
		ch.sig_pe       = s[PE_W-1:0];
		ch.last_channel = last;
		return ch;
	endfunction

	task automatic run_flash(input int len, input bit near_full);
		for (int i = 0; i < len; i++)
			send_channel(make_channel(i == len - 1, near_full));
		random_items += len;
	endtask

	function automatic int flash_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 4);
		if (r < 90)
			return $urandom_range(5, 16);
		return $urandom_range(17, 64);
	endfunction

	initial begin
		int cc;
		int ic;
		int budget;
		verdict_board = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset cuts: extremes, zero hypothesis, channel and integral excess
		send_pair(0, 0, 1);
		send_pair(PE_MAX, 0, 1);
		send_pair(0, PE_MAX, 1);
		send_pair(PE_MAX, PE_MAX, 1);
		send_pair(1600, 0, 0);
		send_pair(0, 1600, 0);
		send_pair(1600, 1600, 1);
		for (int i = 0; i < 10; i++)
			send_pair(1600, 1440, i == 9);
		send_pair(1600, 1440, 0);
		send_pair(1600, 1600, 1);

		// negative cuts
		drain_verdicts(SETTLE);
		write_cut(CFG_CHANNEL_CUT, -16);
		write_cut(CFG_INTEGRAL_CUT, -16);
		send_pair(1600, 1600, 1);
		send_pair(0, 5, 1);
		send_pair(1, PE_MAX, 1);
		send_pair(5, 0, 1);

		budget = RANDOM_ITEMS / N_SETTINGS;
		for (int p = 0; p < N_SETTINGS; p++) begin
			case (p)
				0: begin cc = 4095;  ic = 4095;  end
				1: begin cc = -4096; ic = -4096; end
				2: begin cc = 0;     ic = 0;     end
				3: begin cc = -4096; ic = 4095;  end
				4: begin cc = 4095;  ic = -4096; end
				5: begin cc = 16;    ic = -16;   end
				6: begin
					cc = int'($urandom_range(0, 8191)) - 4096;
					ic = int'($urandom_range(0, 8191)) - 4096;
				end
				7: begin
					cc = int'($urandom_range(0, 320)) - 160;
					ic = int'($urandom_range(0, 320)) - 160;
				end
				default: begin cc = 48; ic = 48; end
			endcase
			drain_verdicts(SETTLE);
			write_cut(CFG_CHANNEL_CUT, cc);
			write_cut(CFG_INTEGRAL_CUT, ic);
			write_cut($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
				int'($urandom_range(0, 8191)));
			// sums saturate past 256 full-scale channels
			if (p == 5 || p == N_SETTINGS - 1)
				run_flash($urandom_range(257, 300), 1'b1);
			while (random_items < budget * (p + 1))
				run_flash(flash_length(), 1'b0);
		end

		drain_verdicts(DRAIN);
		$display("Covered %0d channel transactions in %0d flashes over %0d cut settings,",
			verdict_board.channels_seen, verdict_board.flashes_seen, N_SETTINGS + 2);
		$display("verdicts: %0d compatible, %0d channel excess, %0d integral excess.",
			verdict_board.n_compatible, verdict_board.n_channel_excess,
			verdict_board.n_integral_excess);
		if (verdict_board.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- files.f -----
sv/fhc_pkg.sv
sv/fhc_front.sv
sv/fhc_queue.sv
sv/fhc_back.sv
sv/flash_hypothesis_compatibility.sv
tb/fhc_verdict_pkg.sv
tb/testbench.sv
